// ===== rtl/bcd_clock_regs_to_epoch_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the BCD clock register to epoch converter.
// Each use expands into one labeled concurrent assertion on the rising edge of
// the given clock, disabled while the given reset is high.
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_REGS_TO_EPOCH_UNIT_MACROS_SVH
`define BCD_CLOCK_REGS_TO_EPOCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define BCRTE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcrte assertion failed");

// Next-cycle implication.
`define BCRTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcrte assertion failed");

`endif

// ===== rtl/bcrte_pkg.sv =====
// ----------------------------------------------------------------------------
// bcrte_pkg
// Types, constants and helper functions shared by the converter's stages.
// ----------------------------------------------------------------------------
package bcrte_pkg;

  // Input transfer: six raw clock-chip register bytes.
  typedef struct packed {
    logic [7:0] seconds_byte;
    logic [7:0] minutes_byte;
    logic [7:0] hours_byte;
    logic [7:0] date_byte;
    logic [7:0] month_byte;
    logic [7:0] year_byte;
  } bcrte_in_t;

  // Output transfer.
  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic        valid_res;
  } bcrte_out_t;

  // After decode: year index k = (year - 1999) in the March-based calendar.
  typedef struct packed {
    logic       ok;
    logic [7:0] year_idx;
    logic [8:0] month_days;
    logic [4:0] date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } bcrte_s1_t;

  // After day count and time of day.
  typedef struct packed {
    logic        ok;
    logic [16:0] days;
    logic [16:0] tod;
  } bcrte_s2_t;

  // After scaling days to seconds.
  typedef struct packed {
    logic        ok;
    logic [33:0] total;
  } bcrte_s3_t;

  // Day number of 1999-03-01 relative to 1970-01-01, less one for the
  // one-based date.
  localparam logic [16:0] DAY_BASE      = 17'd10650;
  localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
  // Year index of March 2100, the first non-leap century in range.
  localparam logic [7:0]  CENTURY_IDX   = 8'd101;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // BCD byte to binary; nibbles above nine are not rejected.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return ({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
  endfunction

  // Days from the first of March to the first of the given month.
  function automatic logic [8:0] month_offset(input logic [7:0] m);
    logic [8:0] r;
    unique case (m)
      8'd1:    r = 9'd306;
      8'd2:    r = 9'd337;
      8'd3:    r = 9'd0;
      8'd4:    r = 9'd31;
      8'd5:    r = 9'd61;
      8'd6:    r = 9'd92;
      8'd7:    r = 9'd122;
      8'd8:    r = 9'd153;
      8'd9:    r = 9'd184;
      8'd10:   r = 9'd214;
      8'd11:   r = 9'd245;
      8'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bcrte_decode.sv =====
// ----------------------------------------------------------------------------
// bcrte_decode
// First stage: masks flag bits, decodes BCD fields and the 12/24-hour mode,
// range-checks every field but the year and forms the March-based year index.
// ----------------------------------------------------------------------------
module bcrte_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bcrte_pkg::bcrte_in_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output bcrte_pkg::bcrte_s1_t dn_data
);
  import bcrte_pkg::*;

  logic [7:0] sec_bin;
  logic [7:0] min_bin;
  logic [7:0] h12_bin;
  logic [7:0] h24_bin;
  logic [7:0] date_bin;
  logic [7:0] month_bin;
  logic [7:0] year_bin;
  logic [4:0] hour;
  logic       hour_ok;
  logic       early_month;
  bcrte_s1_t  dn_data_next;

  always_comb begin
    sec_bin   = bcd_to_bin({1'b0, up_data.seconds_byte[6:0]});
    min_bin   = bcd_to_bin({1'b0, up_data.minutes_byte[6:0]});
    h12_bin   = bcd_to_bin({3'b000, up_data.hours_byte[4:0]});
    h24_bin   = bcd_to_bin({2'b00, up_data.hours_byte[5:0]});
    date_bin  = bcd_to_bin({2'b00, up_data.date_byte[5:0]});
    month_bin = bcd_to_bin({3'b000, up_data.month_byte[4:0]});
    year_bin  = bcd_to_bin(up_data.year_byte);

    if (up_data.hours_byte[6]) begin
      // Twelve o'clock counts as hour zero, and PM adds twelve.
      hour    = ((h12_bin == 8'd12) ? 5'd0 : h12_bin[4:0]) +
                (up_data.hours_byte[5] ? 5'd12 : 5'd0);
      hour_ok = (h12_bin >= 8'd1) && (h12_bin <= 8'd12);
    end else begin
      hour    = h24_bin[4:0];
      hour_ok = (h24_bin <= 8'd23);
    end

    // January and February belong to the previous March-based year.
    early_month = (month_bin <= 8'd2);

    dn_data_next.ok = hour_ok && (sec_bin <= 8'd59) && (min_bin <= 8'd59) &&
                      (date_bin >= 8'd1) && (date_bin <= 8'd31) &&
                      (month_bin >= 8'd1) && (month_bin <= 8'd12);
    dn_data_next.year_idx   = year_bin + 8'd1 - {7'd0, early_month};
    dn_data_next.month_days = month_offset(month_bin);
    dn_data_next.date       = date_bin[4:0];
    dn_data_next.hour       = hour;
    dn_data_next.minute     = min_bin[5:0];
    dn_data_next.second     = sec_bin[5:0];
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= dn_data_next;
    end
  end

endmodule

// ===== rtl/bcrte_days.sv =====
// ----------------------------------------------------------------------------
// bcrte_days
// Second stage: day count since 1970-01-01 and seconds into the day.
// ----------------------------------------------------------------------------
module bcrte_days (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bcrte_pkg::bcrte_s1_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output bcrte_pkg::bcrte_s2_t dn_data
);
  import bcrte_pkg::*;

  logic [7:0] leap_idx;
  bcrte_s2_t  dn_data_next;

  always_comb begin
    // Leap days: one every four years, less one from March 2100 on.
    leap_idx = (up_data.year_idx + 8'd3) >> 2;
    dn_data_next.ok   = up_data.ok;
    dn_data_next.days = DAY_BASE + ({9'd0, up_data.year_idx} * DAYS_PER_YEAR) +
                        {9'd0, leap_idx} -
                        {16'd0, (up_data.year_idx >= CENTURY_IDX)} +
                        {8'd0, up_data.month_days} + {12'd0, up_data.date};
    dn_data_next.tod  = ({12'd0, up_data.hour} * SECS_PER_HOUR) +
                        ({11'd0, up_data.minute} * SECS_PER_MIN) +
                        {11'd0, up_data.second};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= dn_data_next;
    end
  end

endmodule

// ===== rtl/bcrte_scale.sv =====
// ----------------------------------------------------------------------------
// bcrte_scale
// Third stage: scales the day count to seconds and adds the time of day.
// ----------------------------------------------------------------------------
module bcrte_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bcrte_pkg::bcrte_s2_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output bcrte_pkg::bcrte_s3_t dn_data
);
  import bcrte_pkg::*;

  bcrte_s3_t dn_data_next;

  always_comb begin
    dn_data_next.ok    = up_data.ok;
    dn_data_next.total = ({17'd0, up_data.days} * {17'd0, SECS_PER_DAY}) +
                         {17'd0, up_data.tod};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= dn_data_next;
    end
  end

endmodule

// ===== rtl/bcd_clock_regs_to_epoch_unit.sv =====
// ----------------------------------------------------------------------------
// bcd_clock_regs_to_epoch_unit
// Converts a snapshot of real-time-clock BCD registers to Unix seconds.
// ----------------------------------------------------------------------------
// The unit takes one register snapshot per clock cycle while req_ready is high
// and returns exactly one result for each, in order, at the output register
// once it is through the pipeline. The four register stages are decode and
// range check, day count with time of day, the 17 by 17 bit multiply that
// scales days to seconds, and the output register that applies the 32-bit
// limit. Each stage has its own valid bit and takes a new item whenever it is
// empty or its contents move on, so bubbles are squeezed out and an item can
// still be accepted while a finished result waits on a low rsp_ready. The
// year is 2000 plus the BCD year byte, the hour register may be in 12-hour or
// 24-hour mode, and the date is not checked against the length of the month.
// Any field out of range, or a count past 32 bits (early 2106 on), returns
// valid_res low with epoch_seconds zero. There are no configuration registers
// and no state is kept between items.
module bcd_clock_regs_to_epoch_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  bcrte_pkg::bcrte_in_t  req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output bcrte_pkg::bcrte_out_t rsp_data
);
  import bcrte_pkg::*;

  logic       s1_valid;
  logic       s1_ready;
  bcrte_s1_t  s1_data;
  logic       s2_valid;
  logic       s2_ready;
  bcrte_s2_t  s2_data;
  logic       s3_valid;
  logic       s3_ready;
  bcrte_s3_t  s3_data;
  logic       fits;
  bcrte_out_t rsp_data_next;

  // Stage one: field decode and range checks.
  bcrte_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .up_data  (req_data),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Stage two: days since the epoch and seconds into the day.
  bcrte_days u_days (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // Stage three: days times 86400 plus the time of day.
  bcrte_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // Output stage. The total is at most 34 bits wide; anything in the top two
  // bits means the count no longer fits an unsigned 32-bit word. Invalid
  // results are forced to zero so the payload never carries a partial count.
  always_comb begin
    fits                        = (s3_data.total[33:32] == 2'b00);
    rsp_data_next.valid_res     = s3_data.ok && fits;
    rsp_data_next.epoch_seconds = rsp_data_next.valid_res ? s3_data.total[31:0] : 32'd0;
  end

  // The output register frees as soon as its result is taken, so a stall on
  // the output side only backs up the pipeline once every stage is full.
  assign s3_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s3_ready) begin
      rsp_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s3_ready) begin
      rsp_data <= rsp_data_next;
    end
  end

endmodule

// ===== rtl/bcrte_checker.sv =====
// ----------------------------------------------------------------------------
// bcrte_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "bcd_clock_regs_to_epoch_unit_macros.svh"

module bcrte_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input bcrte_pkg::bcrte_out_t rsp_data
);
  import bcrte_pkg::*;

  // A rejected result carries no partial count.
  `BCRTE_ASSERT_SAME(a_invalid_is_zero, clk, rst, rsp_valid && !rsp_data.valid_res, rsp_data.epoch_seconds == 32'd0)

  // A result that is not taken stays put.
  `BCRTE_ASSERT_NEXT(a_rsp_holds, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

  // With the output register empty, every stage can move, so input is taken.
  `BCRTE_ASSERT_SAME(a_ready_when_drained, clk, rst, !rsp_valid, req_ready)

  // An accepted item moves through the stages to the output unless stalled.
  `BCRTE_ASSERT_SAME(a_latency, clk, rst, $past(req_valid && req_ready, 4) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && $past(rsp_ready, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 3), rsp_valid)

endmodule

bind bcd_clock_regs_to_epoch_unit bcrte_checker u_bcrte_checker (.*);
